// ----- design/nrwl_pkg.sv -----
// shared types and constants of the node reader-writer lock table
package nrwl_pkg;

	localparam int WORD_W      = 32;
	localparam int NODE_W      = 8;
	localparam int TID_W       = 5;
	// reader bit of a thread sits this far above bit 0
	localparam int READER_BASE = 2;
	// first thread whose reader bit no longer fits in a word
	localparam int TID_FIT     = WORD_W - READER_BASE;

	typedef enum logic [3:0] {
		CMD_RD_ACQ       = 4'd0,
		CMD_RD_REL       = 4'd1,
		CMD_WR_PEND      = 4'd2,
		CMD_WR_DONE      = 4'd3,
		CMD_WR_ABORT     = 4'd4,
		CMD_WR_REL       = 4'd5,
		CMD_WR_REL_IF3   = 4'd6,
		CMD_DEGRADE      = 4'd7,
		CMD_RRD_ACQ      = 4'd8,
		CMD_RRD_REL      = 4'd9,
		CMD_RWR_PEND     = 4'd10,
		CMD_RWR_TRYPEND  = 4'd11,
		CMD_RWR_DONE     = 4'd12,
		CMD_RWR_NOWAIT   = 4'd13,
		CMD_RWR_REL      = 4'd14,
		CMD_COMBINED_REL = 4'd15
	} cmd_e_t;

	localparam logic [WORD_W-1:0] INS_HELD    = 32'd1;
	localparam logic [WORD_W-1:0] INS_PENDING = 32'd2;
	localparam logic [WORD_W-1:0] INS_BOTH    = 32'd3;
	localparam logic [WORD_W-1:0] REM_PENDING = 32'd1;
	localparam logic [WORD_W-1:0] REM_HELD    = 32'd3;

	typedef struct packed {
		cmd_e_t            command;
		logic [NODE_W-1:0] node_index;
		logic [TID_W-1:0]  thread_id;
	} req_t;

	typedef struct packed {
		logic              granted;
		logic [WORD_W-1:0] insert_word_after;
		logic [WORD_W-1:0] remove_word_after;
	} rsp_t;

	// both lock words of one node as stored in the table
	typedef struct packed {
		logic [WORD_W-1:0] ins;
		logic [WORD_W-1:0] rem;
	} pair_t;

endpackage

// ----- design/nrwl_ram.sv -----
// generic single-port-write, registered-read ram
module nrwl_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- design/nrwl_step.sv -----
// lock word update for one command on one node
module nrwl_step (
	input  nrwl_pkg::cmd_e_t                 command,
	input  logic [nrwl_pkg::TID_W-1:0]       thread_id,
	input  logic                             tid_ok,
	input  nrwl_pkg::pair_t                  cur,
	output nrwl_pkg::rsp_t                   result
);

	logic [nrwl_pkg::WORD_W-1:0] rbit;
	logic [nrwl_pkg::WORD_W-1:0] ins;
	logic [nrwl_pkg::WORD_W-1:0] rem;
	logic                        ok;
	logic                        uses_rbit;

	assign rbit = tid_ok ? (nrwl_pkg::WORD_W'(1) <<
		({1'b0, thread_id} + 6'(nrwl_pkg::READER_BASE))) : '0;

	assign uses_rbit = command inside {nrwl_pkg::CMD_RD_ACQ, nrwl_pkg::CMD_RD_REL,
		nrwl_pkg::CMD_DEGRADE, nrwl_pkg::CMD_RRD_ACQ, nrwl_pkg::CMD_RRD_REL,
		nrwl_pkg::CMD_COMBINED_REL};

	always_comb begin
		ins = cur.ins;
		rem = cur.rem;
		ok  = 1'b1;
		if (uses_rbit && !tid_ok) begin
			ok = 1'b0;
		end else begin
			case (command)
				nrwl_pkg::CMD_RD_ACQ: begin
					if ((cur.ins & nrwl_pkg::INS_BOTH) == '0) ins = cur.ins | rbit;
					else ok = 1'b0;
				end
				nrwl_pkg::CMD_RD_REL: ins = cur.ins & ~rbit;
				nrwl_pkg::CMD_WR_PEND: begin
					if ((cur.ins & nrwl_pkg::INS_PENDING) != '0) ok = 1'b0;
					else ins = cur.ins | nrwl_pkg::INS_PENDING;
				end
				nrwl_pkg::CMD_WR_DONE: begin
					if (cur.ins == nrwl_pkg::INS_PENDING) ins = nrwl_pkg::INS_BOTH;
					else ok = 1'b0;
				end
				nrwl_pkg::CMD_WR_ABORT: ins = cur.ins & ~nrwl_pkg::INS_PENDING;
				nrwl_pkg::CMD_WR_REL: ins = cur.ins & ~nrwl_pkg::INS_BOTH;
				nrwl_pkg::CMD_WR_REL_IF3: begin
					if (cur.ins == nrwl_pkg::INS_BOTH) ins = '0;
					else ok = 1'b0;
				end
				nrwl_pkg::CMD_DEGRADE: ins = rbit | (cur.ins & ~nrwl_pkg::INS_BOTH);
				nrwl_pkg::CMD_RRD_ACQ: begin
					if ((cur.rem & nrwl_pkg::REM_PENDING) == '0) rem = cur.rem | rbit;
					else ok = 1'b0;
				end
				nrwl_pkg::CMD_RRD_REL: rem = cur.rem & ~rbit;
				nrwl_pkg::CMD_RWR_PEND: rem = cur.rem | nrwl_pkg::REM_PENDING;
				nrwl_pkg::CMD_RWR_TRYPEND: begin
					if ((cur.rem & nrwl_pkg::REM_PENDING) != '0) ok = 1'b0;
					else rem = cur.rem | nrwl_pkg::REM_PENDING;
				end
				nrwl_pkg::CMD_RWR_DONE: begin
					// on refusal pending is asserted again
					if (cur.rem == nrwl_pkg::REM_PENDING) begin
						rem = nrwl_pkg::REM_HELD;
					end else begin
						rem = cur.rem | nrwl_pkg::REM_PENDING;
						ok  = 1'b0;
					end
				end
				nrwl_pkg::CMD_RWR_NOWAIT: begin
					if (cur.rem == '0) rem = nrwl_pkg::REM_HELD;
					else ok = 1'b0;
				end
				nrwl_pkg::CMD_RWR_REL: begin
					if (cur.rem == nrwl_pkg::REM_HELD) rem = '0;
					else ok = 1'b0;
				end
				default: begin
					ins = cur.ins & ~nrwl_pkg::INS_BOTH;
					rem = cur.rem & ~rbit;
				end
			endcase
		end
	end

	assign result.granted           = ok;
	assign result.insert_word_after = ins;
	assign result.remove_word_after = rem;

endmodule

// ----- design/node_rw_lock_table.sv -----
// top level of the node reader-writer lock table
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------------
//  req     | in        | req_valid/req_stall | command, node_index, thread_id
//  rsp     | out       | rsp_valid/rsp_stall | granted, insert_word_after, remove_word_after
//
// one request per cycle sustained while rsp is not stalled; the table ram read is issued
// at the edge that takes the request; the update stage writes back and fills rsp_q
// a write and a read of the same node in the same cycle are resolved by forwarding
// the last written pair, so back-to-back requests to one node see each other
// reset clears one valid bit per table entry at once; no clearing pass is needed
// while rsp is stalled with a response waiting, the request in the update stage
// holds and req_stall is raised
module node_rw_lock_table #(
	parameter int NODE_COUNT   = 256,
	parameter int THREAD_COUNT = 30
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  nrwl_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output nrwl_pkg::rsp_t  rsp
);

	// only 8-bit node indexes reach the table
	localparam int DEPTH = (NODE_COUNT < (1 << nrwl_pkg::NODE_W)) ?
		NODE_COUNT : (1 << nrwl_pkg::NODE_W);
	localparam int AW = $clog2(DEPTH);
	localparam logic [16:0] NODE_LIMIT = 17'(NODE_COUNT);
	localparam logic [6:0]  THREAD_LIMIT = 7'(THREAD_COUNT);
	localparam int PAIR_W = $bits(nrwl_pkg::pair_t);

	// stage 1: request waiting on its ram read
	logic            valid_s1;
	nrwl_pkg::req_t  req_s1;
	logic            in_range_s1;
	logic            tid_ok_s1;

	// last write, for forwarding into stage 1
	logic            wr_valid_q;
	logic [AW-1:0]   wr_addr_q;
	nrwl_pkg::pair_t wr_data_q;

	logic [DEPTH-1:0] ent_valid_q;

	logic            rsp_valid_q;
	nrwl_pkg::rsp_t  rsp_q;

	logic            req_take;
	logic            s1_go;
	logic            wr_en;
	logic [AW-1:0]   addr_s1;
	logic [PAIR_W-1:0] rd_data;
	nrwl_pkg::pair_t cur;
	nrwl_pkg::pair_t next_pair;
	nrwl_pkg::rsp_t  step_rsp;
	logic            req_in_range;
	logic            req_tid_ok;

	// the update stage moves on when the response register is free or drains
	assign s1_go     = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !s1_go;
	assign req_take  = req_valid && !req_stall;

	assign req_in_range = {9'd0, req.node_index} < NODE_LIMIT;
	assign req_tid_ok   = ({2'd0, req.thread_id} < THREAD_LIMIT) &&
		({2'd0, req.thread_id} < 7'(nrwl_pkg::TID_FIT));

	assign addr_s1 = req_s1.node_index[AW-1:0];

	nrwl_ram #(
		.WIDTH(PAIR_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk     (clk),
		.rd_en   (req_take),
		.rd_addr (req.node_index[AW-1:0]),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (next_pair)
	);

	// newest value of the node: a write at the read edge is not seen by the ram read
	always_comb begin
		if (wr_valid_q && wr_addr_q == addr_s1) begin
			cur = wr_data_q;
		end else if (ent_valid_q[addr_s1]) begin
			cur = nrwl_pkg::pair_t'(rd_data);
		end else begin
			cur = '0;
		end
	end

	nrwl_step u_step (
		.command   (req_s1.command),
		.thread_id (req_s1.thread_id),
		.tid_ok    (tid_ok_s1),
		.cur       (cur),
		.result    (step_rsp)
	);

	assign next_pair.ins = step_rsp.insert_word_after;
	assign next_pair.rem = step_rsp.remove_word_after;

	// out-of-range nodes leave the table alone
	assign wr_en = valid_s1 && s1_go && in_range_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			wr_valid_q  <= 1'b0;
			ent_valid_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// an empty update stage takes a request even while rsp is stalled
			if (!req_stall) begin
				valid_s1 <= req_take;
			end
			if (s1_go) begin
				rsp_valid_q <= valid_s1;
			end
			if (wr_en) begin
				wr_valid_q           <= 1'b1;
				ent_valid_q[addr_s1] <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_take) begin
			req_s1      <= req;
			in_range_s1 <= req_in_range;
			tid_ok_s1   <= req_tid_ok;
		end
		if (wr_en) begin
			wr_addr_q <= addr_s1;
			wr_data_q <= next_pair;
		end
		if (s1_go && valid_s1) begin
			rsp_q <= in_range_s1 ? step_rsp : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// a blocked update stage keeps its request
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_go |=> valid_s1 && $stable(req_s1))
		else $error("update stage lost its request while blocked");

	// the forwarding register always names an entry marked as written
	a_fwd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid_q |-> ent_valid_q[wr_addr_q])
		else $error("forwarded entry not marked valid");

	// an in-range update is captured for forwarding at the next edge
	a_fwd_capture: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> wr_valid_q && wr_addr_q == $past(addr_s1))
		else $error("write back not captured for forwarding");

	// request stall only while a response waits and is stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid_q && rsp_stall)
		else $error("request stalled without a blocked response");

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the node reader-writer lock table
`timescale 1ns / 100ps

module testbench;

	localparam int NODES        = 256;
	localparam int THREADS      = 30;
	// cycles with no request or response taken before the run is declared hung
	localparam int QUIET_LIMIT  = 1000;
	localparam int REPORT_LIMIT = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	nrwl_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	nrwl_pkg::rsp_t rsp;

	// shadow copy of both lock words per node, cleared like the block after reset
	logic [nrwl_pkg::WORD_W-1:0] ins_table [NODES] = '{default: '0};
	logic [nrwl_pkg::WORD_W-1:0] rem_table [NODES] = '{default: '0};

	// outcomes predicted at request time, oldest first
	nrwl_pkg::rsp_t outcome_q [$];

	int  mismatches = 0;
	int  requests_sent = 0;
	int  quiet_cycles = 0;
	int  stall_left = 0;
	// random gaps on the request side and stalls on the response side
	bit  idle_on = 1'b0;

	node_rw_lock_table #(
		.NODE_COUNT  (NODES),
		.THREAD_COUNT(THREADS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one atomic attempt on one node: returns granted and both words after the step
	function automatic nrwl_pkg::rsp_t apply_lock_step(input nrwl_pkg::req_t r);
		logic [nrwl_pkg::WORD_W-1:0] iw, rw, rbit;
		logic ok, tid_ok, uses_rbit;
		nrwl_pkg::rsp_t res;
		// node outside the table: nothing changes, all-zero response
		if (r.node_index >= NODES)
			return '0;
		iw = ins_table[r.node_index];
		rw = rem_table[r.node_index];
		// a thread beyond the count, or whose reader bit would fall off the word
		tid_ok = (r.thread_id < THREADS) && (r.thread_id < nrwl_pkg::TID_FIT);
		rbit = tid_ok ? (nrwl_pkg::WORD_W'(1) << (r.thread_id + nrwl_pkg::READER_BASE))
			: '0;
		case (r.command)
			nrwl_pkg::CMD_RD_ACQ, nrwl_pkg::CMD_RD_REL, nrwl_pkg::CMD_DEGRADE,
			nrwl_pkg::CMD_RRD_ACQ, nrwl_pkg::CMD_RRD_REL,
			nrwl_pkg::CMD_COMBINED_REL: uses_rbit = 1'b1;
			default:                    uses_rbit = 1'b0;
		endcase
		ok = 1'b1;
		if (uses_rbit && !tid_ok) begin
			ok = 1'b0;
		end else begin
			case (r.command)
				nrwl_pkg::CMD_RD_ACQ: begin
					if ((iw & nrwl_pkg::INS_BOTH) == '0) iw = iw | rbit;
					else ok = 1'b0;
				end
				nrwl_pkg::CMD_RD_REL:  iw = iw & ~rbit;
				nrwl_pkg::CMD_WR_PEND: begin
					if ((iw & nrwl_pkg::INS_PENDING) != '0) ok = 1'b0;
					else iw = iw | nrwl_pkg::INS_PENDING;
				end
				nrwl_pkg::CMD_WR_DONE: begin
					// only a lone pending writer, no readers, may take the lock
					if (iw == nrwl_pkg::INS_PENDING) iw = nrwl_pkg::INS_BOTH;
					else ok = 1'b0;
				end
				nrwl_pkg::CMD_WR_ABORT: iw = iw & ~nrwl_pkg::INS_PENDING;
				nrwl_pkg::CMD_WR_REL:   iw = iw & ~nrwl_pkg::INS_BOTH;
				nrwl_pkg::CMD_WR_REL_IF3: begin
					if (iw == nrwl_pkg::INS_BOTH) iw = '0;
					else ok = 1'b0;
				end
				// drop the write bits and keep the caller as a reader
				nrwl_pkg::CMD_DEGRADE: iw = rbit | (iw & ~nrwl_pkg::INS_BOTH);
				nrwl_pkg::CMD_RRD_ACQ: begin
					if ((rw & nrwl_pkg::REM_PENDING) == '0) rw = rw | rbit;
					else ok = 1'b0;
				end
				nrwl_pkg::CMD_RRD_REL:  rw = rw & ~rbit;
				nrwl_pkg::CMD_RWR_PEND: rw = rw | nrwl_pkg::REM_PENDING;
				nrwl_pkg::CMD_RWR_TRYPEND: begin
					if ((rw & nrwl_pkg::REM_PENDING) != '0) ok = 1'b0;
					else rw = rw | nrwl_pkg::REM_PENDING;
				end
				nrwl_pkg::CMD_RWR_DONE: begin
					// a refused attempt still leaves pending asserted
					if (rw == nrwl_pkg::REM_PENDING) begin
						rw = nrwl_pkg::REM_HELD;
					end else begin
						rw = rw | nrwl_pkg::REM_PENDING;
						ok = 1'b0;
					end
				end
				nrwl_pkg::CMD_RWR_NOWAIT: begin
					if (rw == '0) rw = nrwl_pkg::REM_HELD;
					else ok = 1'b0;
				end
				nrwl_pkg::CMD_RWR_REL: begin
					if (rw == nrwl_pkg::REM_HELD) rw = '0;
					else ok = 1'b0;
				end
				// combined release
				default: begin
					iw = iw & ~nrwl_pkg::INS_BOTH;
					rw = rw & ~rbit;
				end
			endcase
		end
		ins_table[r.node_index] = iw;
		rem_table[r.node_index] = rw;
		res = '{granted: ok, insert_word_after: iw, remove_word_after: rw};
		return res;
	endfunction

	// predict each request as it is taken, in order of acceptance
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall)
			outcome_q.push_back(apply_lock_step(req));
	end

	// compare each response taken with the oldest prediction
	always @(posedge clk) begin
		nrwl_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (outcome_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected response: granted %0b ins %h rem %h",
						rsp.granted, rsp.insert_word_after, rsp.remove_word_after);
			end else begin
				want = outcome_q.pop_front();
				if (rsp.granted !== want.granted ||
						rsp.insert_word_after !== want.insert_word_after ||
						rsp.remove_word_after !== want.remove_word_after) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("response mismatch: expected granted %0b ins %h rem %h,",
							want.granted, want.insert_word_after, want.remove_word_after,
							" got granted %0b ins %h rem %h",
							rsp.granted, rsp.insert_word_after, rsp.remove_word_after);
				end
			end
		end
	end

	// response side back-pressure in bursts of random length
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 2);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// hang detector: nothing taken on either side for too long
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// present one request and hold it until taken; valid stays high on return
	task automatic send_request(input nrwl_pkg::cmd_e_t cmd,
			input logic [nrwl_pkg::NODE_W-1:0] node,
			input logic [nrwl_pkg::TID_W-1:0] tid);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= '{command: cmd, node_index: node, thread_id: tid};
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		requests_sent++;
	endtask

	// stop requesting and let every predicted response come back
	task automatic wait_drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outcome_q.size() != 0)
			@(posedge clk);
	endtask

	// a few hot nodes at both ends of the table so requests collide
	function automatic logic [nrwl_pkg::NODE_W-1:0] pick_node();
		int n;
		n = $urandom_range(0, 7);
		return (n < 4) ? nrwl_pkg::NODE_W'(n) : nrwl_pkg::NODE_W'(248 + n);
	endfunction

	// mostly a small pool of threads, sometimes any valid one, rarely out of range
	function automatic logic [nrwl_pkg::TID_W-1:0] pick_thread();
		int roll;
		roll = $urandom_range(0, 15);
		if (roll == 0)
			return nrwl_pkg::TID_W'($urandom_range(30, 31));
		else if (roll < 5)
			return nrwl_pkg::TID_W'($urandom_range(0, 29));
		return nrwl_pkg::TID_W'($urandom_range(0, 7));
	endfunction

	// insert word: readers, a writer pending behind them, hand-off, degrade
	task automatic test_insert_lock();
		send_request(nrwl_pkg::CMD_RD_ACQ, 8'd255, 5'd0);
		send_request(nrwl_pkg::CMD_RD_ACQ, 8'd255, 5'd29);
		send_request(nrwl_pkg::CMD_WR_PEND, 8'd255, 5'd1);
		// pending writer blocks new readers, readers block the writer
		send_request(nrwl_pkg::CMD_RD_ACQ, 8'd255, 5'd5);
		send_request(nrwl_pkg::CMD_WR_DONE, 8'd255, 5'd1);
		send_request(nrwl_pkg::CMD_RD_REL, 8'd255, 5'd0);
		send_request(nrwl_pkg::CMD_RD_REL, 8'd255, 5'd29);
		send_request(nrwl_pkg::CMD_WR_DONE, 8'd255, 5'd1);
		send_request(nrwl_pkg::CMD_WR_PEND, 8'd255, 5'd2);
		send_request(nrwl_pkg::CMD_WR_REL_IF3, 8'd255, 5'd1);
		send_request(nrwl_pkg::CMD_WR_PEND, 8'd255, 5'd1);
		send_request(nrwl_pkg::CMD_WR_ABORT, 8'd255, 5'd1);
		// top reader bit, then a thread past the count
		send_request(nrwl_pkg::CMD_DEGRADE, 8'd255, 5'd29);
		send_request(nrwl_pkg::CMD_RD_ACQ, 8'd255, 5'd30);
		send_request(nrwl_pkg::CMD_WR_REL, 8'd255, 5'd3);
	endtask

	// remove word: reader vs pending writer, refused done re-asserts pending
	task automatic test_remove_lock();
		send_request(nrwl_pkg::CMD_RRD_ACQ, 8'd0, 5'd0);
		send_request(nrwl_pkg::CMD_RWR_TRYPEND, 8'd0, 5'd1);
		send_request(nrwl_pkg::CMD_RWR_TRYPEND, 8'd0, 5'd2);
		send_request(nrwl_pkg::CMD_RWR_DONE, 8'd0, 5'd1);
		send_request(nrwl_pkg::CMD_RRD_REL, 8'd0, 5'd0);
		send_request(nrwl_pkg::CMD_RWR_DONE, 8'd0, 5'd1);
		send_request(nrwl_pkg::CMD_RWR_REL, 8'd0, 5'd1);
		send_request(nrwl_pkg::CMD_RWR_NOWAIT, 8'd0, 5'd4);
		send_request(nrwl_pkg::CMD_RWR_PEND, 8'd0, 5'd4);
		// combined release with a thread whose reader bit does not exist
		send_request(nrwl_pkg::CMD_COMBINED_REL, 8'd0, 5'd31);
		send_request(nrwl_pkg::CMD_COMBINED_REL, 8'd0, 5'd2);
		send_request(nrwl_pkg::CMD_RWR_REL, 8'd0, 5'd4);
	endtask

	// well-formed lock sequences with random content, plus some noise
	task automatic run_lock_mix(input int count);
		int stop_at;
		logic [nrwl_pkg::NODE_W-1:0] node;
		logic [nrwl_pkg::TID_W-1:0] tid;
		stop_at = requests_sent + count;
		while (requests_sent < stop_at) begin
			node = pick_node();
			tid = pick_thread();
			case ($urandom_range(0, 9))
				0, 1: begin
					send_request(nrwl_pkg::CMD_RD_ACQ, node, tid);
					if ($urandom_range(0, 4) != 0)
						send_request(nrwl_pkg::CMD_RD_REL, node, tid);
				end
				2, 3: begin
					send_request(nrwl_pkg::CMD_WR_PEND, node, tid);
					send_request(nrwl_pkg::CMD_WR_DONE, node, tid);
					case ($urandom_range(0, 3))
						0: send_request(nrwl_pkg::CMD_WR_REL_IF3, node, tid);
						1: send_request(nrwl_pkg::CMD_WR_REL, node, tid);
						2: begin
							send_request(nrwl_pkg::CMD_DEGRADE, node, tid);
							send_request(nrwl_pkg::CMD_RD_REL, node, tid);
						end
						default: send_request(nrwl_pkg::CMD_WR_ABORT, node, tid);
					endcase
				end
				4: begin
					send_request(nrwl_pkg::CMD_RRD_ACQ, node, tid);
					send_request(nrwl_pkg::CMD_RRD_REL, node, tid);
				end
				5: begin
					send_request($urandom_range(0, 1) ? nrwl_pkg::CMD_RWR_PEND
						: nrwl_pkg::CMD_RWR_TRYPEND, node, tid);
					repeat ($urandom_range(1, 2))
						send_request(nrwl_pkg::CMD_RWR_DONE, node, tid);
					send_request(nrwl_pkg::CMD_RWR_REL, node, tid);
				end
				6: begin
					send_request(nrwl_pkg::CMD_RWR_NOWAIT, node, tid);
					send_request(nrwl_pkg::CMD_RWR_REL, node, tid);
				end
				7: send_request(nrwl_pkg::CMD_COMBINED_REL, node, tid);
				default: begin
					// anything at all, anywhere in the table
					repeat ($urandom_range(1, 3))
						send_request(nrwl_pkg::cmd_e_t'($urandom_range(0, 15)),
							nrwl_pkg::NODE_W'($urandom_range(0, 255)),
							nrwl_pkg::TID_W'($urandom_range(0, 31)));
				end
			endcase
		end
	endtask

	// random sequences with gaps and back-pressure on both sides
	task automatic test_contended_traffic();
		idle_on = 1'b1;
		run_lock_mix(580);
	endtask

	// same mix at full rate, so forwarding between neighbors is exercised
	task automatic test_back_to_back();
		idle_on = 1'b0;
		run_lock_mix(150);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;
		test_insert_lock();
		test_remove_lock();
		test_contended_traffic();
		test_back_to_back();
		wait_drain();
		// two-stage pipe: leave room for any response that should not exist
		repeat (10) @(posedge clk);
		mismatches = mismatches + outcome_q.size();
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
